@@ hdl/ksel_pkg.sv @@
// shared types and constants for the k-th smallest selector
`timescale 1ns / 1ps
package ksel_pkg;

  localparam int MAX_RANK = 64;
  localparam int IDX_W    = $clog2(MAX_RANK);
  localparam int CNT_W    = $clog2(MAX_RANK + 1);
  localparam int DATA_W   = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    data_t value;
    logic  last;
  } in_req_t;

  typedef struct packed {
    data_t kth_value;
    logic  too_few;
  } out_rsp_t;

  // per-cell control from the top level
  typedef struct packed {
    logic load;         // request accepted this cycle
    logic valid;        // cell holds a kept value
    logic append_here;  // cell is the next free slot and the store grows
  } cell_ctrl_t;

endpackage

@@ hdl/kth_smallest_select.sv @@
// streaming k-th smallest selector built on a sorted insertion chain
//
//  channel  | dir | handshake                  | payload
//  ---------+-----+----------------------------+------------------------------
//  cfg      | in  | cfg_we_i                   | cfg_wdata_i (k_index)
//  in       | in  | in_valid_i / in_ready_o    | in_req_i (value, last)
//  out      | out | out_valid_o / out_ready_i  | out_rsp_o (kth_value, too_few)
//
// one request per cycle for values that do not end a set, while no end-of-set
// read is pending; the chain of 64 cells compares the new value against every
// kept value at once; a request with last set is taken in by the chain, then
// the cell at rank k_index is read into the output register and the store
// empties; that read waits for the output register to be free, in_ready_o
// stays low until then; a waiting result does not block ordinary values
// reset clears the fill count, rank register and output valid; the cell
// contents are not reset and need no clearing pass
`timescale 1ns / 1ps
module kth_smallest_select (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ksel_pkg::IDX_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ksel_pkg::in_req_t          in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ksel_pkg::out_rsp_t         out_rsp_o
);

  localparam int NC = ksel_pkg::MAX_RANK;
  localparam int CW = ksel_pkg::CNT_W;

  // rank register
  logic [ksel_pkg::IDX_W-1:0] k_q;

  // number of kept values and the end-of-set read pending flag
  logic [CW-1:0] count_q, count_d;
  logic          pend_q, pend_d;

  logic               out_valid_q, out_valid_d;
  ksel_pkg::out_rsp_t out_rsp_q, out_rsp_d;

  logic          accept;
  logic          append;
  logic          out_free;
  logic          read_out;
  logic [CW-1:0] cap;

  ksel_pkg::data_t      cell_val [NC];
  logic                 cell_gt  [NC];
  ksel_pkg::cell_ctrl_t cell_ctrl[NC];

  assign in_ready_o = !pend_q;
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign read_out   = pend_q && out_free;

  // store grows while below rank+1, otherwise a smaller value replaces the largest
  assign cap    = CW'(k_q) + CW'(1);
  assign append = count_q < cap;

  // the cell row: each cell sees the broadcast value and its left neighbor
  for (genvar g = 0; g < NC; g++) begin : g_cell
    assign cell_ctrl[g].load        = accept;
    assign cell_ctrl[g].valid       = CW'(g) < count_q;
    assign cell_ctrl[g].append_here = append && (CW'(g) == count_q);

    if (g == 0) begin : g_head
      ksel_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (cell_ctrl[g]),
        .value_i     (in_req_i.value),
        .prev_value_i(in_req_i.value),
        .prev_gt_i   (1'b0),
        .value_o     (cell_val[g]),
        .gt_o        (cell_gt[g])
      );
    end else begin : g_body
      ksel_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (cell_ctrl[g]),
        .value_i     (in_req_i.value),
        .prev_value_i(cell_val[g-1]),
        .prev_gt_i   (cell_gt[g-1]),
        .value_o     (cell_val[g]),
        .gt_o        (cell_gt[g])
      );
    end
  end

  always_comb begin
    count_d     = count_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      if (append) begin
        count_d = count_q + CW'(1);
      end
      pend_d = in_req_i.last;
    end

    // end of set: pick rank k and empty the store
    if (read_out) begin
      out_valid_d = 1'b1;
      if (count_q > CW'(k_q)) begin
        out_rsp_d.kth_value = cell_val[k_q];
        out_rsp_d.too_few   = 1'b0;
      end else begin
        out_rsp_d.kth_value = '0;
        out_rsp_d.too_few   = 1'b1;
      end
      count_d = '0;
      pend_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        k_q <= cfg_wdata_i;
      end
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

@@ hdl/ksel_cell.sv @@
// one cell of the sorted insertion chain
`timescale 1ns / 1ps
module ksel_cell (
  input  logic                clk_i,
  input  ksel_pkg::cell_ctrl_t ctrl_i,
  input  ksel_pkg::data_t     value_i,
  input  ksel_pkg::data_t     prev_value_i,
  input  logic                prev_gt_i,
  output ksel_pkg::data_t     value_o,
  output logic                gt_o
);

  ksel_pkg::data_t value_q;
  ksel_pkg::data_t value_d;

  // kept value strictly above the new one: it moves right
  assign gt_o    = ctrl_i.valid && (value_q > value_i);
  assign value_o = value_q;

  always_comb begin
    if (prev_gt_i) begin
      value_d = prev_value_i;
    end else if (gt_o || !ctrl_i.valid) begin
      value_d = value_i;
    end else begin
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && (ctrl_i.valid || ctrl_i.append_here)) begin
      value_q <= value_d;
    end
  end

endmodule

@@ hdl/ksel_chk.sv @@
// port-level checks for the k-th smallest selector
`timescale 1ns / 1ps
module ksel_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input ksel_pkg::in_req_t          in_req_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input ksel_pkg::out_rsp_t         out_rsp_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // too_few results carry a zero value
  a_too_few_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.too_few |-> out_rsp_o.kth_value == '0)
    else $error("too_few result with nonzero value");

  // a last request blocks the input for the readout cycle
  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_req_i.last |=> !in_ready_o)
    else $error("input ready right after end of set");

  // input only stalls behind a pending end of set
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> $past(in_acc && in_req_i.last) || $past(!in_ready_o))
    else $error("input stalled without an end of set");

  // a result appears only after an end of set was taken
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without end of set");

endmodule

bind kth_smallest_select ksel_chk u_ksel_chk (.*);

@@ verif/kth_smallest_select_tb.sv @@
// self-checking testbench for the streaming k-th smallest selector
`timescale 1ns / 1ps
module kth_smallest_select_tb;

  localparam int unsigned STALL_LIMIT = 2000;  // cycles with no handshake or register write
  localparam int unsigned ITEMS_PER_MODE = 233;
  localparam int unsigned PHASE_ITEMS = 40;

  // clock, reset and block inputs, all known from time zero
  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [ksel_pkg::IDX_W-1:0] cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  ksel_pkg::in_req_t          in_req_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  ksel_pkg::out_rsp_t         out_rsp_o;

  // stimulus waiting for the driver and results still owed by the block
  ksel_pkg::in_req_t  value_req_q[$];
  ksel_pkg::out_rsp_t pending_kth_q[$];

  // shadow of the selector: sorted kept values, their count and the rank
  ksel_pkg::data_t kept_vals [ksel_pkg::MAX_RANK];
  int unsigned     kept_num = 0;
  int unsigned     rank_sel = 0;

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned items_queued = 0;
  ksel_pkg::out_rsp_t want_rsp;

  kth_smallest_select DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // take one value into the kept set: grow while below rank+1, otherwise
  // replace the largest kept value only when strictly smaller; an inserted
  // value lands after any kept values equal to it
  function automatic void absorb_value(ksel_pkg::data_t v);
    int unsigned n;
    int p;
    if (kept_num < rank_sel + 1) begin
      n = kept_num + 1;
    end else if (kept_num > 0 && v < kept_vals[kept_num-1]) begin
      n = kept_num;
    end else begin
      return;
    end
    kept_num = n;
    p = 0;
    while (p + 1 < int'(n) && kept_vals[p] <= v) p++;
    for (int i = int'(n) - 1; i > p; i--) kept_vals[i] = kept_vals[i-1];
    kept_vals[p] = v;
  endfunction

  // expected result of one accepted request, if it closes a set
  function automatic void predict_request(ksel_pkg::in_req_t req);
    ksel_pkg::out_rsp_t rsp;
    absorb_value(req.value);
    if (req.last) begin
      if (kept_num > rank_sel) begin
        rsp.kth_value = kept_vals[rank_sel];
        rsp.too_few   = 1'b0;
      end else begin
        // set too short for the rank: zero value, flag raised
        rsp.kth_value = '0;
        rsp.too_few   = 1'b1;
      end
      pending_kth_q.push_back(rsp);
      kept_num = 0;
    end
  endfunction

  // driver: holds each request until accepted, idles at random between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
    end else begin
      if (in_valid_i && in_ready_o) predict_request(in_req_i);
      if (!in_valid_i || in_ready_o) begin
        if (value_req_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_req_i   <= value_req_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: every accepted result against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_kth_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result value %0d too_few %0b",
                                  out_rsp_o.kth_value, out_rsp_o.too_few));
        end else begin
          want_rsp = pending_kth_q.pop_front();
          if (out_rsp_o.kth_value !== want_rsp.kth_value)
            flag_mismatch($sformatf("kth_value %0d, expected %0d",
                                    out_rsp_o.kth_value, want_rsp.kth_value));
          if (out_rsp_o.too_few !== want_rsp.too_few)
            flag_mismatch($sformatf("too_few %0b, expected %0b",
                                    out_rsp_o.too_few, want_rsp.too_few));
        end
      end
      out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // watchdog: any handshake or register write restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic push_req(ksel_pkg::data_t v, logic is_last);
    ksel_pkg::in_req_t req;
    req.value = v;
    req.last  = is_last;
    value_req_q.push_back(req);
    items_queued++;
  endtask

  // checked at the falling edge so the driver's updates have settled;
  // the sender stays paused here until every owed result has come back
  task automatic wait_quiet(int unsigned settle);
    do @(negedge clk_i);
    while (value_req_q.size() != 0 || in_valid_i || pending_kth_q.size() != 0);
    // an accepted value is already in the chain; this wait only adds margin
    repeat (settle) @(posedge clk_i);
  endtask

  // rank register written only with the block idle
  task automatic set_rank(int unsigned k);
    wait_quiet(8);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= k[ksel_pkg::IDX_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    rank_sel = k;
  endtask

  function automatic ksel_pkg::data_t pick_value(int unsigned flavor);
    case (flavor)
      0: return ksel_pkg::data_t'($urandom);
      1: return ksel_pkg::data_t'($urandom_range(8) - 4);  // narrow range, many ties
      default: begin
        case ($urandom_range(3))
          0: return ksel_pkg::data_t'(32'h8000_0000);
          1: return ksel_pkg::data_t'(32'h7fff_ffff);
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // one set of random values; closed sets end with last, open ones carry on
  task automatic queue_set(int unsigned len, bit closed);
    int unsigned flavor;
    flavor = $urandom_range(3);
    for (int unsigned i = 0; i < len; i++)
      push_req(pick_value(flavor == 3 ? $urandom_range(2) : flavor), closed && (i == len - 1));
  endtask

  initial begin
    int unsigned k;
    int unsigned len;
    int unsigned mode_start;
    int unsigned phase_start;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    sender_idle_pct   = 23;
    receiver_idle_pct = 71;

    // directed: rank 2, extremes of the value range
    set_rank(2);
    push_req(ksel_pkg::data_t'(32'h7fff_ffff), 1'b0);
    push_req(ksel_pkg::data_t'(32'h8000_0000), 1'b0);
    push_req('0, 1'b0);
    push_req('1, 1'b0);
    push_req(5, 1'b1);
    // ties: equal values fill the store, a smaller one evicts the last tie
    push_req(7, 1'b0);
    push_req(7, 1'b0);
    push_req(7, 1'b0);
    push_req(3, 1'b1);
    // sets with rank or fewer values report too_few
    push_req(1, 1'b0);
    push_req(2, 1'b1);
    push_req(-5, 1'b1);
    // open set, rank lowered in mid-set
    push_req(10, 1'b0);
    push_req(20, 1'b0);
    push_req(30, 1'b0);
    set_rank(0);
    push_req(5, 1'b0);
    push_req(4, 1'b1);
    push_req(-1, 1'b0);
    push_req(9, 1'b0);
    // rank raised to the top in mid-set, then the set closes short
    set_rank(ksel_pkg::MAX_RANK - 1);
    push_req(3, 1'b1);

    // random phases under three idling schemes
    for (int mode = 0; mode < 3; mode++) begin
      wait_quiet(2);
      case (mode)
        0: begin
          sender_idle_pct   = 23;
          receiver_idle_pct = 71;
        end
        1: begin
          sender_idle_pct   = 71;
          receiver_idle_pct = 23;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      mode_start = items_queued;
      while (items_queued - mode_start < ITEMS_PER_MODE) begin
        case ($urandom_range(5))
          0: k = 0;
          1: k = ksel_pkg::MAX_RANK - 1;
          2, 3: k = $urandom_range(7);
          default: k = $urandom_range(ksel_pkg::MAX_RANK - 1);
        endcase
        set_rank(k);
        phase_start = items_queued;
        while (items_queued - phase_start < PHASE_ITEMS) begin
          // lengths around the rank boundary, plus short random sets
          case ($urandom_range(4))
            0: len = (k == 0) ? 1 : $urandom_range(1, k);
            1: len = k + 1;
            2: len = k + 1 + $urandom_range(1, 4);
            default: len = $urandom_range(1, 12);
          endcase
          queue_set(len, 1'b1);
        end
        // sometimes leave a set open across the next rank change
        if ($urandom_range(3) == 0) queue_set($urandom_range(1, 3), 1'b0);
      end
    end

    // close any open set so its result is checked too
    push_req(pick_value(0), 1'b1);
    wait_quiet(16);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/ksel_pkg.sv
hdl/ksel_cell.sv
hdl/kth_smallest_select.sv
hdl/ksel_chk.sv
verif/kth_smallest_select_tb.sv
